[hw/rtl/itr_pkg.sv]
// Shared types, status codes and symbol tables for the integer to Roman encoder.
package itr_pkg;

    localparam int VALUE_W  = 12;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;
    localparam int NUM_SYM  = 13;
    localparam int SYM_W    = $clog2(NUM_SYM);
    localparam int Q_DEPTH  = 2;
    localparam int Q_AW     = $clog2(Q_DEPTH);

    localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;

    localparam logic [VALUE_W-1:0] SYM_WEIGHT [NUM_SYM] = '{
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
    };

    localparam logic [CHAR_W-1:0] SYM_FIRST [NUM_SYM] = '{
        8'h4D, 8'h43, 8'h44, 8'h43, 8'h43, 8'h58, 8'h4C,
        8'h58, 8'h58, 8'h49, 8'h56, 8'h49, 8'h49
    };

    // A second letter of zero means the symbol has a single letter.
    localparam logic [CHAR_W-1:0] SYM_SECOND [NUM_SYM] = '{
        8'h00, 8'h4D, 8'h00, 8'h44, 8'h00, 8'h43, 8'h00,
        8'h4C, 8'h00, 8'h58, 8'h00, 8'h56, 8'h00
    };

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] kind;
    } t_item;

endpackage

[hw/rtl/itr_front.sv]
// Input stage: accepts a value, classifies it and holds it for the queue.
module itr_front
    import itr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_push,
    output t_item              o_item,
    input  logic               i_q_ready
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_q_ready;
    assign o_push  = r_valid && i_q_ready;
    assign o_item  = r_item;

    always_comb begin
        n_item.value = i_value;
        if (i_value == '0) begin
            n_item.kind = STATUS_EMPTY;
        end else if (i_value > VALUE_MAX) begin
            n_item.kind = STATUS_INVALID;
        end else begin
            n_item.kind = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

[hw/rtl/itr_queue.sv]
// Short queue of classified items between the front and the back.
module itr_queue
    import itr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wptr;
    logic [Q_AW-1:0]   r_rptr;
    logic [Q_AW:0]     r_count;

    assign o_ready = (r_count != Q_DEPTH[Q_AW:0]);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

[hw/rtl/itr_back.sv]
// Back end: walks the greedy symbol sequence and drives one character per transaction.
module itr_back
    import itr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_item               i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CHAR_W-1:0]   o_symbol,
    output logic                o_last,
    output logic [STATUS_W-1:0] o_status
);

    logic                r_busy;
    logic                r_pend;
    logic [CHAR_W-1:0]   r_pend_char;
    logic [VALUE_W-1:0]  r_rest;
    logic                r_ovalid;
    logic [CHAR_W-1:0]   r_symbol;
    logic                r_last;
    logic [STATUS_W-1:0] r_status;

    logic                out_free;
    logic                emit;
    logic [SYM_W-1:0]    sel;
    logic [VALUE_W-1:0]  n_rest;
    logic                n_last;

    assign out_free = !r_ovalid || i_ready;
    assign o_pop    = i_q_valid && !r_busy && out_free;
    assign emit     = r_busy && out_free;

    // The largest weight not above the remainder is the next greedy symbol.
    always_comb begin
        sel = SYM_W'(NUM_SYM - 1);
        for (int i = NUM_SYM - 1; i >= 0; i--) begin
            if (r_rest >= SYM_WEIGHT[i]) begin
                sel = SYM_W'(i);
            end
        end
        n_rest = r_rest - SYM_WEIGHT[sel];
        n_last = (SYM_SECOND[sel] == CHAR_NONE) && (n_rest == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_free) begin
                r_ovalid <= emit || (o_pop && i_item.kind != STATUS_OK);
            end
            if (o_pop && i_item.kind == STATUS_OK) begin
                r_busy <= 1'b1;
                r_pend <= 1'b0;
            end else if (emit) begin
                if (r_pend) begin
                    r_pend <= 1'b0;
                    r_busy <= (r_rest != '0);
                end else begin
                    r_pend <= (SYM_SECOND[sel] != CHAR_NONE);
                    r_busy <= !n_last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rest <= i_item.value;
            if (i_item.kind != STATUS_OK) begin
                r_symbol <= CHAR_NONE;
                r_last   <= 1'b1;
                r_status <= i_item.kind;
            end
        end else if (emit) begin
            r_status <= STATUS_OK;
            if (r_pend) begin
                r_symbol <= r_pend_char;
                r_last   <= (r_rest == '0);
            end else begin
                r_symbol    <= SYM_FIRST[sel];
                r_pend_char <= SYM_SECOND[sel];
                r_last      <= n_last;
                r_rest      <= n_rest;
            end
        end
    end

    assign o_valid  = r_ovalid;
    assign o_symbol = r_symbol;
    assign o_last   = r_last;
    assign o_status = r_status;

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && o_pop))
        else $error("queue popped while a numeral is in progress");

    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_busy)
        else $error("second letter pending with no numeral in progress");

    a_flag_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_status != STATUS_OK) |-> (r_last && r_symbol == CHAR_NONE))
        else $error("flagged result not a single final transaction");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !r_pend && n_last) |=> !r_busy)
        else $error("sequencer still busy after the final character");

endmodule

[hw/rtl/integer_to_roman_encoder_top.sv]
// A valid value's first character passes the front register, the queue and the back-end
// remainder register to the output; the single flagged result for zero or above 3999 skips
// the remainder register. The back end pops a new value only after the final character of the
// previous numeral (at most 15 characters); one character per cycle unless the output stalls.
// Reset is synchronous and active low; it empties the front stage, queue and output register.
// Top level: integer to Roman numeral encoder.
module integer_to_roman_encoder_top
    import itr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CHAR_W-1:0]   o_symbol,
    output logic                o_last,
    output logic [STATUS_W-1:0] o_status
);

    logic  push;
    logic  pop;
    logic  q_ready;
    logic  q_valid;
    t_item front_item;
    t_item q_item;

    itr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_value   (i_value),
        .o_push    (push),
        .o_item    (front_item),
        .i_q_ready (q_ready)
    );

    itr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    itr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_symbol  (o_symbol),
        .o_last    (o_last),
        .o_status  (o_status)
    );

endmodule

[tb/sv/tb_integer_to_roman_encoder_top.sv]
// Self-checking testbench for the integer to Roman numeral encoder.
module tb_integer_to_roman_encoder_top;
    import itr_pkg::*;

    localparam int TOP_VALUE   = 3999;
    localparam int NUM_GROUPS  = 13;
    localparam int RANDOM_ITEMS = 460;
    localparam int CYCLE_LIMIT = 1_500_000;

    localparam int unsigned GROUP_WEIGHT [NUM_GROUPS] = '{
        1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1
    };
    localparam logic [CHAR_W-1:0] GROUP_LEAD [NUM_GROUPS] = '{
        "M", "C", "D", "C", "C", "X", "L", "X", "X", "I", "V", "I", "I"
    };
    localparam logic [CHAR_W-1:0] GROUP_TAIL [NUM_GROUPS] = '{
        CHAR_NONE, "M", CHAR_NONE, "D", CHAR_NONE, "C", CHAR_NONE,
        "L", CHAR_NONE, "X", CHAR_NONE, "V", CHAR_NONE
    };

    typedef struct packed {
        logic [CHAR_W-1:0]   symbol;
        logic                last;
        logic [STATUS_W-1:0] status;
    } t_roman_char;

    typedef struct {
        logic [VALUE_W-1:0] value;
        bit                 drain;
    } t_pending_value;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [VALUE_W-1:0]  i_value = '0;
    logic                i_ready = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [CHAR_W-1:0]   o_symbol;
    logic                o_last;
    logic [STATUS_W-1:0] o_status;

    t_pending_value value_queue[$];
    t_roman_char    numeral_chars_q[$];
    int             err_count = 0;
    int             sent_count = 0;
    int             char_count = 0;
    int             send_gap = 0;
    int             stall_left = 0;

    integer_to_roman_encoder_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_symbol (o_symbol),
        .o_last   (o_last),
        .o_status (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Appends the characters of the numeral for one accepted value.
    function automatic void predict_numeral(logic [VALUE_W-1:0] value);
        int unsigned rest;
        t_roman_char c;
        rest = value;
        if (rest == 0) begin
            numeral_chars_q.push_back('{CHAR_NONE, 1'b1, STATUS_EMPTY});
        end else if (rest > TOP_VALUE) begin
            numeral_chars_q.push_back('{CHAR_NONE, 1'b1, STATUS_INVALID});
        end else begin
            for (int k = 0; k < NUM_GROUPS; k++) begin
                while (rest >= GROUP_WEIGHT[k]) begin
                    rest -= GROUP_WEIGHT[k];
                    c = '{GROUP_LEAD[k], 1'b0, STATUS_OK};
                    numeral_chars_q.push_back(c);
                    if (GROUP_TAIL[k] != CHAR_NONE) begin
                        c.symbol = GROUP_TAIL[k];
                        numeral_chars_q.push_back(c);
                    end
                end
            end
            numeral_chars_q[numeral_chars_q.size() - 1].last = 1'b1;
        end
    endfunction

    // Mostly back to back, some short gaps, now and then a long one.
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void add_value(logic [VALUE_W-1:0] value, bit drain);
        t_pending_value p;
        p.value = value;
        p.drain = drain;
        value_queue.push_back(p);
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        else if (r < 12)
            return VALUE_W'($urandom_range(TOP_VALUE + 1, 4095));
        else if (r < 30)
            return VALUE_W'($urandom_range(3000, TOP_VALUE));
        else
            return VALUE_W'($urandom_range(1, TOP_VALUE));
    endfunction

    // Driver: presents pending values and holds each until it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_value <= '0;
            send_gap = 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                sent_count++;
                send_gap = pick_gap((sent_count / 50) % 3 == 1);
            end
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (value_queue.size() > 0 &&
                         !(value_queue[0].drain &&
                           (i_valid || numeral_chars_q.size() > 0))) begin
                i_valid <= 1'b1;
                i_value <= value_queue[0].value;
                void'(value_queue.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: predicts on each input transaction and checks each output transaction.
    always @(posedge i_clk) begin
        t_roman_char want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (i_valid && o_ready)
                predict_numeral(i_value);
            if (o_valid && i_ready) begin
                char_count++;
                if (numeral_chars_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result: expected none, %s %h last %b status %0d",
                             $time, "got symbol", o_symbol, o_last, o_status);
                end else begin
                    want = numeral_chars_q.pop_front();
                    if (o_symbol !== want.symbol || o_last !== want.last ||
                        o_status !== want.status) begin
                        err_count++;
                        $display("%0t: mismatch: expected symbol %h last %b status %0d,",
                                 $time, want.symbol, want.last, want.status,
                                 " got symbol %h last %b status %0d",
                                 o_symbol, o_last, o_status);
                    end
                end
                stall_left = pick_gap((char_count / 150) % 3 == 2);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_ready <= (stall_left == 0);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL integer_to_roman_encoder_top");
        $finish;
    end

    initial begin
        logic [VALUE_W-1:0] directed [$];
        directed = '{12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40, 12'd49, 12'd90,
                     12'd99, 12'd400, 12'd444, 12'd900, 12'd999, 12'd1000, 12'd1994,
                     12'd2048, 12'd3888, 12'd3999, 12'd4000, 12'd4001, 12'd4095,
                     12'd2730, 12'd1365};
        foreach (directed[k])
            add_value(directed[k], 1'b0);
        // Each hundredth random value waits until the output side has drained.
        for (int k = 0; k < RANDOM_ITEMS; k++)
            add_value(random_value(), (k % 100) == 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (value_queue.size() > 0 || i_valid || numeral_chars_q.size() > 0);
        repeat (40) @(posedge i_clk);

        if (err_count == 0 && numeral_chars_q.size() == 0)
            $display("PASS integer_to_roman_encoder_top");
        else
            $display("FAIL integer_to_roman_encoder_top");
        $finish;
    end

endmodule
